// ===== sv/stb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants of the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

	localparam int TIMER_COUNT_DEF = 16;
	localparam int TICK_BITS_DEF   = 32;

	localparam int MODE_W   = 2;
	localparam int ID_W     = 6;
	localparam int PERIOD_W = 32;
	localparam int PEND_W   = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_QUERY = 2'd3
	} mode_t;

	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

// ===== sv/stb_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stb_req_if
// Request channel of the timer bank: one command beat per handshake.
// ----------------------------------------------------------------------------
interface stb_req_if;
	logic                         valid;
	logic                         ready;
	logic [stb_pkg::MODE_W-1:0]   mode;
	logic [stb_pkg::ID_W-1:0]     timer_sel;
	logic [stb_pkg::PERIOD_W-1:0] period;
	logic                         notify;

	modport source (output valid, mode, timer_sel, period, notify, input ready);
	modport sink   (input valid, mode, timer_sel, period, notify, output ready);
endinterface
`default_nettype wire

// ===== sv/stb_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stb_rsp_if
// Response channel of the timer bank: events, completions and query answers.
// ----------------------------------------------------------------------------
interface stb_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [stb_pkg::ID_W-1:0]   timer_id_res;
	logic                       active;
	logic                       running;
	logic [stb_pkg::PEND_W-1:0] ticks_left;
	logic                       last;

	modport source (output valid, kind, timer_id_res, active, running, ticks_left, last,
		input ready);
	modport sink   (input valid, kind, timer_id_res, active, running, ticks_left, last,
		output ready);
endinterface
`default_nettype wire

// ===== sv/software_timer_bank.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of one-shot timers over a tick counter that advances on each tick
// command, with expiry times and notify flags held in a RAM.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Beat contents                                   Beats per item
// -------  ---  ----------------------------------------------  --------------
// req      in   mode, timer_sel, period, notify                 1
// rsp      out  kind, timer_id_res, active, running,            1 .. TIMER_COUNT+1
//               ticks_left, last
//
// Start, stop and query pass through the accept, which also issues the RAM
// read, and an execute step that writes the RAM, clears a flag or forms the answer.
// A tick runs through the accept, a scan that visits each timer entry in turn
// as it walks the RAM read port, and the closing completion beat.
// A beat waits while the single output register still holds a stalled beat;
// meanwhile the scan still moves past entries that do not fire.
// Reset clears the tick counter, the active flags and the state machine; the
// RAM needs no clearing, because an inactive entry always reads as expiry zero.
//
// An entry's RAM word holds {notify, expiry}. The active flags sit in flops,
// so they double as valid bits for the RAM: stop and firing only clear the
// flag, and any inactive entry is treated as having expiry zero, which is
// exactly what the timer state would hold.
module software_timer_bank #(
	parameter int TIMER_COUNT = stb_pkg::TIMER_COUNT_DEF,
	parameter int TICK_BITS   = stb_pkg::TICK_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	stb_req_if.sink   req,
	stb_rsp_if.source rsp
);

	localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int WORD_W = TICK_BITS + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);
	localparam logic [stb_pkg::ID_W-1:0] ID_LIMIT = stb_pkg::ID_W'(TIMER_COUNT);

	// Control state.
	stb_pkg::state_t state_q, state_d;
	logic [TICK_BITS-1:0]   now_q;
	logic [TIMER_COUNT-1:0] active_q;
	logic [IDX_W-1:0]       idx_q;

	// The accepted command.
	stb_pkg::mode_t               mode_q;
	logic [stb_pkg::ID_W-1:0]     id_q;
	logic [stb_pkg::PERIOD_W-1:0] period_q;
	logic                         notify_q;

	// Output register.
	logic                       out_valid_q;
	logic                       out_kind_q;
	logic [stb_pkg::ID_W-1:0]   out_id_q;
	logic                       out_act_q;
	logic                       out_run_q;
	logic [stb_pkg::PEND_W-1:0] out_pend_q;
	logic                       out_last_q;

	// RAM port.
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_raddr;
	logic [WORD_W-1:0]     ram_wdata;
	logic [WORD_W-1:0]     ram_rdata;

	// Datapath decode.
	logic                 req_fire;
	logic                 out_free;
	logic                 id_ok;
	logic [IDX_W-1:0]     id_idx;
	logic                 rd_notify;
	logic [TICK_BITS-1:0] rd_expiry;
	logic                 fire;
	logic [TICK_BITS-1:0] q_expiry;
	logic                 q_run;
	logic [TICK_BITS-1:0] q_diff;

	// Per-state controls.
	logic                       emit;
	logic                       emit_kind;
	logic [stb_pkg::ID_W-1:0]   emit_id;
	logic                       emit_act;
	logic                       emit_run;
	logic [stb_pkg::PEND_W-1:0] emit_pend;
	logic                       emit_last;
	logic                       set_act;
	logic                       clr_act;
	logic [IDX_W-1:0]           act_idx;
	logic                       scan_adv;

	stb_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TIMER_COUNT),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (id_idx),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign id_ok     = id_q < ID_LIMIT;
	assign id_idx    = id_q[IDX_W-1:0];
	assign rd_notify = ram_rdata[TICK_BITS];
	assign rd_expiry = ram_rdata[TICK_BITS-1:0];
	assign ram_wdata = {notify_q, now_q + TICK_BITS'(period_q)};

	// During the scan the RAM output belongs to entry idx_q; nothing writes
	// the RAM while a scan runs, so the read data needs no forwarding.
	assign fire = active_q[idx_q] && rd_notify && !(now_q < rd_expiry);

	// Query: an inactive entry reads as expiry zero.
	assign q_expiry = (id_ok && active_q[id_idx]) ? rd_expiry : '0;
	assign q_run    = now_q < q_expiry;
	assign q_diff   = q_expiry - now_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			stb_pkg::ST_IDLE: begin
				if (req_fire) begin
					if (stb_pkg::mode_t'(req.mode) == stb_pkg::MODE_TICK) begin
						state_d = stb_pkg::ST_SCAN;
					end else begin
						state_d = stb_pkg::ST_EXEC;
					end
				end
			end
			stb_pkg::ST_EXEC: begin
				if (out_free) begin
					state_d = stb_pkg::ST_IDLE;
				end
			end
			stb_pkg::ST_SCAN: begin
				if (scan_adv && idx_q == LAST_IDX) begin
					state_d = stb_pkg::ST_FIN;
				end
			end
			stb_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = stb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = idx_q;
		emit      = 1'b0;
		emit_kind = stb_pkg::KIND_DONE;
		emit_id   = id_q;
		emit_act  = 1'b0;
		emit_run  = 1'b0;
		emit_pend = '0;
		emit_last = 1'b1;
		set_act   = 1'b0;
		clr_act   = 1'b0;
		act_idx   = id_idx;
		scan_adv  = 1'b0;
		case (state_q)
			stb_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (stb_pkg::mode_t'(req.mode) == stb_pkg::MODE_TICK) begin
					ram_raddr = '0;
				end else begin
					ram_raddr = req.timer_sel[IDX_W-1:0];
				end
			end
			stb_pkg::ST_EXEC: begin
				ram_raddr = id_idx;
				if (out_free) begin
					emit = 1'b1;
					case (mode_q)
						stb_pkg::MODE_START: begin
							ram_we  = id_ok;
							set_act = id_ok;
						end
						stb_pkg::MODE_STOP: begin
							clr_act = id_ok;
						end
						stb_pkg::MODE_QUERY: begin
							emit_act  = id_ok && active_q[id_idx];
							emit_run  = q_run;
							emit_pend = q_run ? stb_pkg::PEND_W'(q_diff) : '0;
						end
						default: begin
						end
					endcase
				end
			end
			stb_pkg::ST_SCAN: begin
				act_idx  = idx_q;
				scan_adv = !fire || out_free;
				if (fire && out_free) begin
					emit      = 1'b1;
					emit_kind = stb_pkg::KIND_EVENT;
					emit_id   = stb_pkg::ID_W'(idx_q);
					emit_last = 1'b0;
					clr_act   = 1'b1;
				end
				// Move the read on to the next entry only once this one is done.
				ram_raddr = scan_adv ? idx_q + 1'b1 : idx_q;
			end
			stb_pkg::ST_FIN: begin
				emit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stb_pkg::ST_IDLE;
			now_q       <= '0;
			active_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_fire && stb_pkg::mode_t'(req.mode) == stb_pkg::MODE_TICK) begin
				now_q <= now_q + 1'b1;
			end
			if (req_fire) begin
				idx_q <= '0;
			end else if (scan_adv) begin
				idx_q <= idx_q + 1'b1;
			end
			if (set_act) begin
				active_q[act_idx] <= 1'b1;
			end else if (clr_act) begin
				active_q[act_idx] <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_q   <= stb_pkg::mode_t'(req.mode);
			id_q     <= req.timer_sel;
			period_q <= req.period;
			notify_q <= req.notify;
		end
		if (emit) begin
			out_kind_q <= emit_kind;
			out_id_q   <= emit_id;
			out_act_q  <= emit_act;
			out_run_q  <= emit_run;
			out_pend_q <= emit_pend;
			out_last_q <= emit_last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.kind         = out_kind_q;
	assign rsp.timer_id_res = out_id_q;
	assign rsp.active       = out_act_q;
	assign rsp.running      = out_run_q;
	assign rsp.ticks_left   = out_pend_q;
	assign rsp.last         = out_last_q;

endmodule
`default_nettype wire

// ===== sv/stb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire
